[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, operation codes and status codes for the indexed deque.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // Default sizing
  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed field widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes
  localparam op_t OP_PUSH_BACK  = 3'd0;
  localparam op_t OP_PUSH_FRONT = 3'd1;
  localparam op_t OP_POP_BACK   = 3'd2;
  localparam op_t OP_POP_FRONT  = 3'd3;
  localparam op_t OP_READ_IDX   = 3'd4;
  localparam op_t OP_WRITE_IDX  = 3'd5;

  // Status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // Per-transaction info carried from the control stage to the output stage
  typedef struct packed {
    logic    rd_hit;   // successful indexed read, take the memory data
    status_t status;
  } issue_t;

endpackage

`default_nettype wire

[design/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Front pointer and element count, request decode and memory addressing.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
  parameter int AW         = $clog2(DEPTH),
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire deq_pkg::op_t                 operation,
  input  wire logic [DATA_WIDTH-1:0]        data_value,
  input  wire logic [deq_pkg::POS_W-1:0]    position,
  output logic                              we,
  output logic      [AW-1:0]                waddr,
  output logic      [DATA_WIDTH-1:0]        wdata,
  output logic                              re,
  output logic      [AW-1:0]                raddr,
  output deq_pkg::issue_t                   issue,
  output logic      [CW-1:0]                count_next
);

  localparam int CMP_W = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;

  logic [AW-1:0]    front;
  logic [CW-1:0]    count;
  logic [AW-1:0]    front_next;
  logic             full;
  logic             empty;
  logic             in_range;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] count_ext;
  logic [AW-1:0]    idx_slot;
  logic [AW-1:0]    back_slot;
  logic [AW-1:0]    front_dec;
  logic [AW-1:0]    front_inc;
  logic             wr_req;
  logic             rd_req;

  // Ring index: front plus offset, folded once into 0..DEPTH-1
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pos_ext   = CMP_W'(position);
  assign count_ext = CMP_W'(count);
  assign in_range  = (pos_ext < count_ext);

  assign idx_slot  = ring_add(front, pos_ext[AW-1:0]);
  assign back_slot = ring_add(front, count[AW-1:0]);
  assign front_inc = ring_add(front, AW'(1));
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : (front - AW'(1));

  // Decode
  always_comb begin
    front_next = front;
    count_next = count;
    wr_req     = 1'b0;
    rd_req     = 1'b0;
    waddr      = back_slot;
    issue      = '{rd_hit: 1'b0, status: deq_pkg::ST_OK};
    case (operation)
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          issue.status = deq_pkg::ST_FULL;
        end else begin
          wr_req     = 1'b1;
          waddr      = back_slot;
          count_next = count + CW'(1);
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          issue.status = deq_pkg::ST_FULL;
        end else begin
          wr_req     = 1'b1;
          waddr      = front_dec;
          front_next = front_dec;
          count_next = count + CW'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          issue.status = deq_pkg::ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          issue.status = deq_pkg::ST_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - CW'(1);
        end
      end
      deq_pkg::OP_READ_IDX: begin
        if (!in_range) begin
          issue.status = deq_pkg::ST_RANGE;
        end else begin
          rd_req       = 1'b1;
          issue.rd_hit = 1'b1;
        end
      end
      deq_pkg::OP_WRITE_IDX: begin
        if (!in_range) begin
          issue.status = deq_pkg::ST_RANGE;
        end else begin
          wr_req = 1'b1;
          waddr  = idx_slot;
        end
      end
      default: begin
      end
    endcase
  end

  assign we    = accept && wr_req;
  assign re    = accept && rd_req;
  assign raddr = idx_slot;
  assign wdata = data_value;

  // Pointer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

[design/double_ended_queue_indexed.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_indexed
// Bounded double-ended queue in a ring buffer with indexed read and write.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: an operation (push back/front, pop back/front,
//   read or write at a position counted from the front), a data value and a
//   position. m_axis returns exactly one result per request: the read value
//   (zero unless a read succeeds), a status code and the occupancy after the
//   request. Refused requests (push on full, pop on empty, position not below
//   the occupancy) leave the queue unchanged.
//   An accepted request goes through the issue stage, then the output register
//   that holds its result on m_axis. Throughput: one request per cycle while
//   m_axis_tready stays high; pointer and count update at the accepting edge
//   and each request makes at most one memory access, read or write.
//   Reset: rst clears the front pointer, the count and both pipeline valid
//   flags, and holds s_axis_tready low; memory contents are not cleared and
//   unwritten entries are never readable. When m_axis_tready is low the
//   result holds in the output register, one more request can sit in the
//   issue stage, and then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_indexed #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
  parameter int AW         = $clog2(DEPTH),
  parameter int CW         = $clog2(DEPTH + 1),
  parameter int IN_W       = ((deq_pkg::OP_W + DATA_WIDTH + deq_pkg::POS_W + 7) / 8) * 8,
  parameter int OUT_W      = ((DATA_WIDTH + deq_pkg::STATUS_W + CW + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // [2:0] operation, [DATA_WIDTH+2:3] data_value, next 4 bits position, zero pad
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // [DATA_WIDTH-1:0] read_value, next 2 bits status, next CW bits occupancy, zero pad
  output logic      [OUT_W-1:0] m_axis_tdata
);

  localparam int DATA_LO = deq_pkg::OP_W;
  localparam int POS_LO  = DATA_LO + DATA_WIDTH;
  localparam int PAD_W   = OUT_W - DATA_WIDTH - deq_pkg::STATUS_W - CW;

  logic                          accept;
  logic                          advance;
  deq_pkg::op_t                  in_op;
  logic [DATA_WIDTH-1:0]         in_data;
  logic [deq_pkg::POS_W-1:0]     in_pos;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [DATA_WIDTH-1:0]         mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [DATA_WIDTH-1:0]         mem_rdata;
  deq_pkg::issue_t               issue;
  logic [CW-1:0]                 occ_next;

  // Issue stage (memory read in flight)
  logic                          s1_valid;
  deq_pkg::issue_t               s1_info;
  logic [CW-1:0]                 s1_occ;

  // Output register
  logic [DATA_WIDTH-1:0]         out_value;
  deq_pkg::status_t              out_status;
  logic [CW-1:0]                 out_occ;

  // Field unpack
  assign in_op   = s_axis_tdata[deq_pkg::OP_W-1:0];
  assign in_data = s_axis_tdata[POS_LO-1:DATA_LO];
  assign in_pos  = s_axis_tdata[POS_LO+deq_pkg::POS_W-1:POS_LO];

  // Handshake
  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !rst && (!s1_valid || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (in_op),
    .data_value (in_data),
    .position   (in_pos),
    .we         (mem_we),
    .waddr      (mem_waddr),
    .wdata      (mem_wdata),
    .re         (mem_re),
    .raddr      (mem_raddr),
    .issue      (issue),
    .count_next (occ_next)
  );

  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Issue stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Issue stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= issue;
      s1_occ  <= occ_next;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_value  <= s1_info.rd_hit ? mem_rdata : '0;
      out_status <= s1_info.status;
      out_occ    <= s1_occ;
    end
  end

  assign m_axis_tdata = {PAD_W'(0), out_occ, out_status, out_value};

endmodule

`default_nettype wire

[design/deq_checker.sv]
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the indexed deque, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
  parameter int CW         = $clog2(DEPTH + 1),
  parameter int OUT_W      = ((DATA_WIDTH + deq_pkg::STATUS_W + CW + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  localparam int ST_LO  = DATA_WIDTH;
  localparam int OCC_LO = DATA_WIDTH + deq_pkg::STATUS_W;

  logic [DATA_WIDTH-1:0] r_value;
  deq_pkg::status_t      r_status;
  logic [CW-1:0]         r_occ;

  assign r_value  = m_axis_tdata[DATA_WIDTH-1:0];
  assign r_status = m_axis_tdata[OCC_LO-1:ST_LO];
  assign r_occ    = m_axis_tdata[OCC_LO+CW-1:OCC_LO];

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Full refusal only with the queue at capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && r_status == deq_pkg::ST_FULL |-> r_occ == CW'(DEPTH))
    else $error("full status with spare room");

  // Empty refusal only with nothing stored
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && r_status == deq_pkg::ST_EMPTY |-> r_occ == '0)
    else $error("empty status with stored elements");

  // Refused transactions return no data
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && r_status != deq_pkg::ST_OK |-> r_value == '0)
    else $error("data returned on refused transaction");

  // Nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind double_ended_queue_indexed deq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH),
  .CW         (CW),
  .OUT_W      (OUT_W)
) u_deq_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed double-ended queue. Requests are queued
// up front and driven with random gaps; every result is checked field by field
// against a built-in ring-buffer model, with random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH       = deq_pkg::DEPTH_DEFAULT;
  localparam int DATA_W      = deq_pkg::DATA_WIDTH_DEFAULT;
  localparam int OP_W        = deq_pkg::OP_W;
  localparam int POS_W       = deq_pkg::POS_W;
  localparam int STATUS_W    = deq_pkg::STATUS_W;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IN_W        = ((OP_W + DATA_W + POS_W + 7) / 8) * 8;
  localparam int OUT_W       = ((DATA_W + STATUS_W + CNT_W + 7) / 8) * 8;
  localparam int RANDOM_REQS = 1400;
  localparam int MAX_IDLE    = 18;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  // Operation codes the block has no use for
  localparam deq_pkg::op_t OP_SPARE_6 = 3'd6;
  localparam deq_pkg::op_t OP_SPARE_7 = 3'd7;

  typedef struct packed {
    deq_pkg::op_t       op;
    logic [DATA_W-1:0]  value;
    logic [POS_W-1:0]   pos;
  } deq_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  rd;
    deq_pkg::status_t   status;
    logic [CNT_W-1:0]   occ;
  } deq_resp_t;

  typedef struct {
    deq_req_t req;
    bit       drain_first;  // hold off until every result is back
  } pending_req_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // [2:0] operation, [34:3] data_value, [38:35] position, [39] zero
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // [31:0] read_value, [33:32] status, [38:34] occupancy, [39] zero
  logic [OUT_W-1:0] m_axis_tdata;

  // Model state
  logic [DATA_W-1:0] deq_store [DEPTH];
  logic [POS_W-1:0]  deq_front;
  logic [CNT_W-1:0]  deq_count;

  pending_req_t pending_q [$];
  deq_resp_t    expected_resp [$];

  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  req_taken   = 1'b0;
  bit  resp_taken  = 1'b0;
  int  gen_fill    = 0;   // occupancy as the generator sees it

  double_ended_queue_indexed i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("tb: error at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  function automatic int idle_cycles(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Apply one request to the model, return the result it should produce
  function automatic deq_resp_t predict_response(input deq_req_t r);
    deq_resp_t o;
    logic [POS_W-1:0] slot;
    o.rd     = '0;
    o.status = deq_pkg::ST_OK;
    slot     = deq_front + r.pos;
    case (r.op)
      deq_pkg::OP_PUSH_BACK: begin
        if (deq_count >= DEPTH) begin
          o.status = deq_pkg::ST_FULL;
        end else begin
          deq_store[deq_front + deq_count[POS_W-1:0]] = r.value;
          deq_count++;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (deq_count >= DEPTH) begin
          o.status = deq_pkg::ST_FULL;
        end else begin
          deq_front--;
          deq_store[deq_front] = r.value;
          deq_count++;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (deq_count == 0) o.status = deq_pkg::ST_EMPTY;
        else deq_count--;
      end
      deq_pkg::OP_POP_FRONT: begin
        if (deq_count == 0) begin
          o.status = deq_pkg::ST_EMPTY;
        end else begin
          deq_front++;
          deq_count--;
        end
      end
      deq_pkg::OP_READ_IDX: begin
        if (r.pos >= deq_count) o.status = deq_pkg::ST_RANGE;
        else o.rd = deq_store[slot];
      end
      deq_pkg::OP_WRITE_IDX: begin
        if (r.pos >= deq_count) o.status = deq_pkg::ST_RANGE;
        else deq_store[slot] = r.value;
      end
      default: ;
    endcase
    o.occ = deq_count;
    return o;
  endfunction

  task automatic queue_request(input deq_pkg::op_t op, input logic [DATA_W-1:0] value,
                               input logic [POS_W-1:0] pos, input bit drain);
    pending_req_t p;
    p.req.op      = op;
    p.req.value   = value;
    p.req.pos     = pos;
    p.drain_first = drain;
    pending_q.insert(pending_q.size(), p);
    if ((op == deq_pkg::OP_PUSH_BACK || op == deq_pkg::OP_PUSH_FRONT) && gen_fill < DEPTH)
      gen_fill++;
    if ((op == deq_pkg::OP_POP_BACK || op == deq_pkg::OP_POP_FRONT) && gen_fill > 0)
      gen_fill--;
  endtask

  // Request driver: one staged transaction, random gap ahead of each
  pending_req_t staged;
  bit           staged_valid = 1'b0;
  bit           tx_calm      = 1'b0;
  int           tx_gap       = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      staged_valid  = 1'b0;
      tx_gap        = 0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (!staged_valid && pending_q.size() != 0) begin
        staged       = pending_q[0];
        pending_q.delete(0);
        staged_valid = 1'b1;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap = idle_cycles(tx_calm);
      end
      if (!staged_valid) begin
        s_axis_tvalid <= 1'b0;
      end else if (staged.drain_first && expected_resp.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - OP_W - DATA_W - POS_W){1'b0}},
                          staged.req.pos, staged.req.value, staged.req.op};
        staged_valid  = 1'b0;
      end
    end
  end

  // Result side: random stall after each transaction
  bit rx_calm  = 1'b0;
  int rx_stall = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall      = 0;
    end else begin
      if (resp_taken) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_stall = idle_cycles(rx_calm);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: check results, predict accepted requests
  always @(posedge clk) begin : monitor
    deq_resp_t want;
    deq_req_t  got_req;
    logic [DATA_W-1:0]   got_rd;
    deq_pkg::status_t    got_status;
    logic [CNT_W-1:0]    got_occ;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      req_taken  <= 1'b0;
      resp_taken <= 1'b0;
      deq_front  = '0;
      deq_count  = '0;
    end else begin
      req_taken  <= s_axis_tvalid && s_axis_tready;
      resp_taken <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got_rd     = m_axis_tdata[DATA_W-1:0];
        got_status = m_axis_tdata[DATA_W +: STATUS_W];
        got_occ    = m_axis_tdata[DATA_W+STATUS_W +: CNT_W];
        if (expected_resp.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding, data %h",
                                    m_axis_tdata));
        end else begin
          want = expected_resp[0];
          expected_resp.delete(0);
          if (got_rd !== want.rd)
            report_mismatch($sformatf("read_value %h, expected %h", got_rd, want.rd));
          if (got_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
          if (got_occ !== want.occ)
            report_mismatch($sformatf("occupancy %0d, expected %0d", got_occ, want.occ));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        got_req.op    = s_axis_tdata[OP_W-1:0];
        got_req.value = s_axis_tdata[OP_W +: DATA_W];
        got_req.pos   = s_axis_tdata[OP_W+DATA_W +: POS_W];
        expected_resp.insert(expected_resp.size(), predict_response(got_req));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    int   mode, seg_len, push_w, pop_w, r, n_random;
    bit   drain_next;
    deq_pkg::op_t      op;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0]  pos;

    // Directed: refusals on empty, spare codes, wrap of the front pointer,
    // indexed access, last-element pops from either end
    queue_request(deq_pkg::OP_POP_BACK,   '0,           4'd0,  1'b0);
    queue_request(deq_pkg::OP_POP_FRONT,  '1,           4'd15, 1'b0);
    queue_request(deq_pkg::OP_READ_IDX,   '0,           4'd15, 1'b0);
    queue_request(deq_pkg::OP_WRITE_IDX,  '1,           4'd0,  1'b0);
    queue_request(OP_SPARE_6,             '1,           4'd15, 1'b0);
    queue_request(OP_SPARE_7,             '1,           4'd15, 1'b0);
    queue_request(deq_pkg::OP_PUSH_BACK,  '1,           4'd0,  1'b0);
    queue_request(deq_pkg::OP_PUSH_FRONT, '0,           4'd15, 1'b0);
    queue_request(deq_pkg::OP_READ_IDX,   '0,           4'd0,  1'b0);
    queue_request(deq_pkg::OP_READ_IDX,   '0,           4'd1,  1'b0);
    queue_request(deq_pkg::OP_READ_IDX,   '0,           4'd2,  1'b0);
    queue_request(deq_pkg::OP_WRITE_IDX,  32'h5A5A5A5A, 4'd1,  1'b0);
    queue_request(deq_pkg::OP_READ_IDX,   '0,           4'd1,  1'b0);
    queue_request(deq_pkg::OP_WRITE_IDX,  '1,           4'd15, 1'b0);
    queue_request(deq_pkg::OP_POP_FRONT,  '0,           4'd0,  1'b0);
    queue_request(deq_pkg::OP_POP_FRONT,  '0,           4'd0,  1'b0);
    queue_request(deq_pkg::OP_PUSH_FRONT, 32'h80000001, 4'd0,  1'b0);
    queue_request(deq_pkg::OP_POP_BACK,   '0,           4'd0,  1'b0);
    queue_request(deq_pkg::OP_PUSH_BACK,  32'h12345678, 4'd0,  1'b0);
    queue_request(deq_pkg::OP_READ_IDX,   '0,           4'd0,  1'b0);
    queue_request(deq_pkg::OP_POP_FRONT,  '0,           4'd0,  1'b0);

    // Random segments: fill-heavy, drain-heavy, balanced, index-heavy
    n_random   = 0;
    drain_next = 1'b1;
    while (n_random < RANDOM_REQS) begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 60);
      case (mode)
        0:       begin push_w = 70; pop_w = 12; end
        1:       begin push_w = 15; pop_w = 70; end
        2:       begin push_w = 35; pop_w = 35; end
        default: begin push_w = 20; pop_w = 20; end
      endcase
      for (int k = 0; k < seg_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < push_w)
          op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
        else if (r < push_w + pop_w)
          op = $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
        else if (r < 98)
          op = $urandom_range(0, 1) ? deq_pkg::OP_READ_IDX : deq_pkg::OP_WRITE_IDX;
        else
          op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        case ($urandom_range(0, 9))
          0:       val = '0;
          1:       val = '1;
          default: val = $urandom;
        endcase
        if (gen_fill > 0 && $urandom_range(0, 3) != 0)
          pos = POS_W'($urandom_range(0, gen_fill - 1));
        else
          pos = POS_W'($urandom_range(0, DEPTH - 1));
        queue_request(op, val, pos, drain_next && k == 0);
        if (op != OP_SPARE_6 && op != OP_SPARE_7) n_random++;
      end
      drain_next = ($urandom_range(0, 5) == 0);
    end

    // Wait for all requests to go out and all results to come back
    while (pending_q.size() != 0 || staged_valid || s_axis_tvalid) @(posedge clk);
    while (expected_resp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/double_ended_queue_indexed.sv
design/deq_checker.sv
test/tb.sv
